FILE: rtl/core/boxblur_pkg.sv
// ----------------------------------------------------------------------------
// boxblur_pkg
// Shared widths, codes and types for the 3x3 edge-clipped box blur core.
// ----------------------------------------------------------------------------
package boxblur_pkg;

  localparam int PIX_W         = 8;
  localparam int NUM_CH        = 3;
  localparam int WIN_CELLS     = 9;
  localparam int WIDTH_REG_W   = 11;
  localparam int HEIGHT_REG_W  = 16;
  localparam int ROW_W         = HEIGHT_REG_W + 1;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIDTH_RESET   = 1024;
  localparam int HEIGHT_RESET  = 768;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // Divisor handling for the rounded mean: (2*sum + n) / (2*n).
  localparam int CNT_N_W     = 4;
  localparam int NUM_W       = 13;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 20;

  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  typedef struct packed {
    logic [WIN_CELLS-1:0] use_cells;
    logic [CNT_N_W-1:0]   n;
  } mean_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL
  } state_e;

  // ceil(2^RECIP_SHIFT / (2*n)) for the pixel counts that can occur. The
  // rounding error stays below one step for every numerator up to 2*9*255+9.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_N_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      CNT_N_W'(1): r = RECIP_W'(524288);
      CNT_N_W'(2): r = RECIP_W'(262144);
      CNT_N_W'(3): r = RECIP_W'(174763);
      CNT_N_W'(4): r = RECIP_W'(131072);
      CNT_N_W'(6): r = RECIP_W'(87382);
      CNT_N_W'(9): r = RECIP_W'(58255);
      default:     r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/boxblur_line_store.sv
// ----------------------------------------------------------------------------
// boxblur_line_store
// Two previous image rows per column, one read and one write port, registered
// read data.
// ----------------------------------------------------------------------------
module boxblur_line_store #(
  parameter int DEPTH = boxblur_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output boxblur_pkg::line_pair_t rd_data_o,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  boxblur_pkg::line_pair_t wr_data_i
);

  boxblur_pkg::line_pair_t mem [DEPTH];
  boxblur_pkg::line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/boxblur_mean.sv
// ----------------------------------------------------------------------------
// boxblur_mean
// Masked window sum per channel, registered, then a reciprocal multiply that
// yields the half-up rounded mean.
// ----------------------------------------------------------------------------
module boxblur_mean (
  input  logic                                         clk_i,
  input  logic                                         load_i,
  input  boxblur_pkg::pix_t [boxblur_pkg::WIN_CELLS-1:0] win_i,
  input  boxblur_pkg::mean_ctl_t                        ctl_i,
  output boxblur_pkg::pix_t                             mean_o
);

  localparam int COL_SUM_W = 10;
  localparam int SUM_W     = 12;
  localparam int PROD_W    = boxblur_pkg::NUM_W + boxblur_pkg::RECIP_W;

  logic [boxblur_pkg::NUM_CH-1:0][2:0][COL_SUM_W-1:0]     col_sum;
  logic [boxblur_pkg::NUM_CH-1:0][SUM_W-1:0]              total;
  logic [boxblur_pkg::NUM_CH-1:0][boxblur_pkg::NUM_W-1:0] num_d;
  logic [boxblur_pkg::NUM_CH-1:0][boxblur_pkg::NUM_W-1:0] num_q;
  logic [boxblur_pkg::RECIP_W-1:0]                        recip_q;
  logic [boxblur_pkg::NUM_CH-1:0][PROD_W-1:0]             prod;

  // Column sums first, then the three columns, to keep the adder depth short.
  always_comb begin
    for (int k = 0; k < boxblur_pkg::NUM_CH; k++) begin
      for (int c = 0; c < 3; c++) begin
        col_sum[k][c] =
            (ctl_i.use_cells[c*3]   ? COL_SUM_W'(win_i[c*3][k])   : '0) +
            (ctl_i.use_cells[c*3+1] ? COL_SUM_W'(win_i[c*3+1][k]) : '0) +
            (ctl_i.use_cells[c*3+2] ? COL_SUM_W'(win_i[c*3+2][k]) : '0);
      end
      total[k] = SUM_W'(col_sum[k][0]) + SUM_W'(col_sum[k][1]) + SUM_W'(col_sum[k][2]);
      num_d[k] = {total[k], 1'b0} + boxblur_pkg::NUM_W'(ctl_i.n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q   <= num_d;
      recip_q <= boxblur_pkg::recip(ctl_i.n);
    end
  end

  always_comb begin
    for (int k = 0; k < boxblur_pkg::NUM_CH; k++) begin
      prod[k]   = PROD_W'(num_q[k]) * PROD_W'(recip_q);
      mean_o[k] = prod[k][boxblur_pkg::RECIP_SHIFT +: boxblur_pkg::PIX_W];
    end
  end

endmodule

FILE: rtl/core/box_blur_3x3_edge_clipped_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_core
// Streaming 3x3 box blur of an RGB raster; the mean covers only neighbors
// inside the image, rounded half up.
// ----------------------------------------------------------------------------
//
//   channel | handshake                | payload
//   --------+--------------------------+---------------------------------------
//   in      | in_valid_i / in_stall_o  | op_i, red_in_i, green_in_i, blue_in_i
//   out     | out_valid_o / out_stall_i| red_out_o, green_out_o, blue_out_o,
//           |                          | frame_last_o
//   cfg     | psel, penable, pready    | paddr, pwrite, pwdata, prdata
//
// An item that gives no result passes through the transfer and the line store
// read; one that gives a result then goes on to the window sum and the
// reciprocal multiply. A drain that is ignored is taken in the idle state.
// The input stalls right after reset and in the cycle after each register write.
// A finished result waits in the output register; the next transfer is taken
// meanwhile, and the multiply stage holds until that register frees up.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_core #(
  parameter int MAX_WIDTH = boxblur_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [boxblur_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [boxblur_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [boxblur_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic [boxblur_pkg::PIX_W-1:0]        red_in_i,
  input  logic [boxblur_pkg::PIX_W-1:0]        green_in_i,
  input  logic [boxblur_pkg::PIX_W-1:0]        blue_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [boxblur_pkg::PIX_W-1:0]        red_out_o,
  output logic [boxblur_pkg::PIX_W-1:0]        green_out_o,
  output logic [boxblur_pkg::PIX_W-1:0]        blue_out_o,
  output logic                                 frame_last_o
);

  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > boxblur_pkg::WIDTH_REG_W) ? WW : boxblur_pkg::WIDTH_REG_W;
  localparam int TW  = boxblur_pkg::HEIGHT_REG_W + WW;
  localparam int RW  = boxblur_pkg::ROW_W;
  localparam int HW  = boxblur_pkg::HEIGHT_REG_W;

  // Configuration registers.
  logic [boxblur_pkg::WIDTH_REG_W-1:0] cfg_width_q;
  logic [HW-1:0]                       cfg_height_q;
  logic                                cfg_we;
  logic                                cfg_dirty_q;

  // Effective frame geometry.
  logic [EW-1:0] w_ext;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [TW-1:0] total_q;

  // Frame position.
  logic [RW-1:0]  row_q;
  logic [CLW-1:0] col_q;
  logic [TW-1:0]  emitted_q;

  // Per-item decode at transfer time.
  logic                   in_fire;
  logic                   taking;
  logic                   drop;
  logic                   step_go;
  boxblur_pkg::pix_t      pix_in;
  logic                   ci_nz;
  logic                   emit;
  logic [RW-1:0]          ro;
  logic [CLW-1:0]         co;
  logic [WW-1:0]          col_inc;
  logic                   wrap;
  logic [CLW-1:0]         col_nxt;
  logic [RW-1:0]          row_nxt;
  logic [TW-1:0]          emitted_nxt;
  logic                   restart;
  logic                   last;
  logic [2:0]             rows_ok;
  logic [2:0]             cols_ok;
  logic [1:0]             row_cnt;
  logic [1:0]             col_cnt;
  boxblur_pkg::mean_ctl_t ctl_d;

  // Item registers.
  boxblur_pkg::pix_t      pix_q;
  logic [CLW-1:0]         col_addr_q;
  boxblur_pkg::mean_ctl_t ctl_q;
  logic                   emit_q;
  logic                   last_q;

  boxblur_pkg::pix_t [boxblur_pkg::WIN_CELLS-1:0] win_q;
  boxblur_pkg::line_pair_t                         line_rd;
  boxblur_pkg::line_pair_t                         line_wr;
  boxblur_pkg::pix_t                               mean;

  boxblur_pkg::state_e state_q, state_d;
  logic                mem_we;
  logic                mean_load;
  logic                out_load;
  logic                out_free;

  logic                         out_valid_q;
  boxblur_pkg::pix_t            out_pix_q;
  logic                         out_last_q;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= boxblur_pkg::WIDTH_REG_W'(boxblur_pkg::WIDTH_RESET);
      cfg_height_q <= HW'(boxblur_pkg::HEIGHT_RESET);
      cfg_dirty_q  <= 1'b1;
    end else begin
      cfg_dirty_q <= cfg_we;
      if (cfg_we) begin
        case (paddr[2])
          boxblur_pkg::REG_IMAGE_WIDTH:
            cfg_width_q <= pwdata[boxblur_pkg::WIDTH_REG_W-1:0];
          boxblur_pkg::REG_IMAGE_HEIGHT:
            cfg_height_q <= pwdata[HW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2])
      boxblur_pkg::REG_IMAGE_WIDTH:  prdata = boxblur_pkg::CFG_DATA_W'(cfg_width_q);
      boxblur_pkg::REG_IMAGE_HEIGHT: prdata = boxblur_pkg::CFG_DATA_W'(cfg_height_q);
      default:                       prdata = '0;
    endcase
  end

  // Width clips to 1..MAX_WIDTH, height zero counts as one row.
  assign w_ext = EW'(cfg_width_q);
  assign w_eff = (cfg_width_q == '0)     ? WW'(1) :
                 (w_ext > EW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext);
  assign h_eff = (cfg_height_q == '0) ? HW'(1) : cfg_height_q;

  // The pixel total is registered; the stall after each write covers its update.
  always_ff @(posedge clk_i) begin
    total_q <= TW'(h_eff) * TW'(w_eff);
  end

  // ------------------------------------------------------------ item decode
  assign in_fire = in_valid_i && !in_stall_o;
  assign taking  = row_q < RW'(h_eff);
  assign drop    = (op_i == boxblur_pkg::OP_DRAIN) && taking;
  assign step_go = in_fire && !drop;

  always_comb begin
    pix_in[boxblur_pkg::CH_RED]   = red_in_i;
    pix_in[boxblur_pkg::CH_GREEN] = green_in_i;
    pix_in[boxblur_pkg::CH_BLUE]  = blue_in_i;

    ci_nz = col_q != '0;
    emit  = ((row_q >= RW'(2)) || ((row_q == RW'(1)) && ci_nz)) && (emitted_q < total_q);

    // Center of the window that completes with this item.
    ro = ci_nz ? row_q - RW'(1) : row_q - RW'(2);
    co = ci_nz ? col_q - CLW'(1) : CLW'(w_eff - WW'(1));

    rows_ok[0] = ro != '0;
    rows_ok[1] = 1'b1;
    rows_ok[2] = (ro + RW'(1)) < RW'(h_eff);
    cols_ok[0] = co != '0;
    cols_ok[1] = 1'b1;
    cols_ok[2] = (WW'(co) + WW'(1)) < w_eff;

    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        ctl_d.use_cells[c*3+r] = cols_ok[c] && rows_ok[r];
      end
    end
    row_cnt = 2'(1) + 2'(rows_ok[0]) + 2'(rows_ok[2]);
    col_cnt = 2'(1) + 2'(cols_ok[0]) + 2'(cols_ok[2]);
    ctl_d.n = boxblur_pkg::CNT_N_W'(row_cnt) * boxblur_pkg::CNT_N_W'(col_cnt);

    col_inc = WW'(col_q) + WW'(1);
    wrap    = col_inc >= w_eff;
    col_nxt = wrap ? '0 : CLW'(col_inc);
    row_nxt = wrap ? row_q + RW'(1) : row_q;

    emitted_nxt = emitted_q + TW'(emit);
    last        = emit && (emitted_nxt == total_q);
    restart     = (emitted_nxt >= total_q) || (row_nxt > (RW'(h_eff) + RW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      emitted_q <= '0;
      emit_q    <= 1'b0;
    end else if (step_go) begin
      emit_q <= emit;
      if (restart) begin
        row_q     <= '0;
        col_q     <= '0;
        emitted_q <= '0;
      end else begin
        row_q     <= row_nxt;
        col_q     <= col_nxt;
        emitted_q <= emitted_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      pix_q      <= taking ? pix_in : '0;
      col_addr_q <= col_q;
      ctl_q      <= ctl_d;
      last_q     <= last;
    end
  end

  // ----------------------------------------------------- line store, window
  assign line_wr.upper  = line_rd.middle;
  assign line_wr.middle = pix_q;

  boxblur_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CLW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (step_go),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (col_addr_q),
    .wr_data_i (line_wr)
  );

  // Stale window columns only ever sit at positions outside the image.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int i = 0; i < boxblur_pkg::WIN_CELLS - 3; i++) begin
        win_q[i] <= win_q[i+3];
      end
      win_q[6] <= line_rd.upper;
      win_q[7] <= line_rd.middle;
      win_q[8] <= pix_q;
    end
  end

  boxblur_mean u_mean (
    .clk_i  (clk_i),
    .load_i (mean_load),
    .win_i  (win_q),
    .ctl_i  (ctl_q),
    .mean_o (mean)
  );

  // ---------------------------------------------------------------- control
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      boxblur_pkg::ST_IDLE: begin
        if (step_go) begin
          state_d = boxblur_pkg::ST_READ;
        end
      end
      boxblur_pkg::ST_READ: begin
        state_d = emit_q ? boxblur_pkg::ST_SUM : boxblur_pkg::ST_IDLE;
      end
      boxblur_pkg::ST_SUM: begin
        state_d = boxblur_pkg::ST_MUL;
      end
      boxblur_pkg::ST_MUL: begin
        if (out_free) begin
          state_d = boxblur_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = boxblur_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mean_load  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      boxblur_pkg::ST_IDLE: in_stall_o = cfg_dirty_q;
      boxblur_pkg::ST_READ: mem_we     = 1'b1;
      boxblur_pkg::ST_SUM:  mean_load  = 1'b1;
      boxblur_pkg::ST_MUL:  out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= boxblur_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= mean;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_pix_q[boxblur_pkg::CH_RED];
  assign green_out_o  = out_pix_q[boxblur_pkg::CH_GREEN];
  assign blue_out_o   = out_pix_q[boxblur_pkg::CH_BLUE];
  assign frame_last_o = out_last_q;

endmodule

FILE: rtl/core/boxblur_chk.sv
// ----------------------------------------------------------------------------
// boxblur_chk
// Port-level checks for the box blur core, attached by bind.
// ----------------------------------------------------------------------------
module boxblur_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          op_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [boxblur_pkg::PIX_W-1:0] red_out_o,
  input logic [boxblur_pkg::PIX_W-1:0] green_out_o,
  input logic [boxblur_pkg::PIX_W-1:0] blue_out_o,
  input logic                          frame_last_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=>
      $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) &&
      $stable(frame_last_o))
    else $error("result payload changed while stalled");

  // A pushed pixel always occupies the block for its line store read.
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o && (op_i == boxblur_pkg::OP_PUSH) |=> in_stall_o)
    else $error("input taken right after a pixel transfer");

  // The cycle after a register write takes no item.
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      psel && penable && pwrite |=> in_stall_o)
    else $error("input taken right after a register write");

  // A new result only comes out of the multiply stage, which holds the input.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without the block being busy");

endmodule

bind box_blur_3x3_edge_clipped_core boxblur_chk u_boxblur_chk (.*);
